// ===== hdl/csa_pkg.sv =====
// csa_pkg: shared types and constants for the checked signed alu
// no dependencies
package csa_pkg;

    localparam int unsigned DataWidth = 32;
    localparam int unsigned DivSteps  = 8;
    localparam int unsigned DivBits   = 4;

    typedef logic signed [DataWidth-1:0] t_data;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_RANGE   = 2'd1,
        ST_DIVZERO = 2'd2,
        ST_RSVD    = 2'd3
    } t_status;

    typedef struct packed {
        logic    vld;
        t_cmd    cmd;
        logic    neg_q;
        logic    zero_b;
        logic    ovf_div;
    } t_ctl;

endpackage

// ===== hdl/csa_mul.sv =====
// csa_mul: signed 32x32 multiply as four 16x16 partial products over two stages
// depends on csa_pkg
module csa_mul (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [31:0]             i_a,
    input  logic [31:0]             i_b,
    output logic [63:0]             o_p
);
    import csa_pkg::*;

    logic [33:0] r_ll, r_lh, r_hl, r_hh;
    logic [63:0] r_p;

    // signed operands split into unsigned low and signed high halves
    logic signed [16:0] a_lo, b_lo, a_hi, b_hi;
    assign a_lo = {1'b0, i_a[15:0]};
    assign b_lo = {1'b0, i_b[15:0]};
    assign a_hi = {i_a[31], i_a[31:16]};
    assign b_hi = {i_b[31], i_b[31:16]};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll <= 34'(a_lo * b_lo);
            r_lh <= 34'(a_lo * b_hi);
            r_hl <= 34'(a_hi * b_lo);
            r_hh <= 34'(a_hi * b_hi);
        end
    end

    logic signed [63:0] sum;
    always_comb begin
        sum = 64'(signed'(r_ll))
            + (64'(signed'(r_lh)) <<< 16)
            + (64'(signed'(r_hl)) <<< 16)
            + (64'(signed'(r_hh)) <<< 32);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= sum;
        end
    end

    assign o_p = r_p;
endmodule

// ===== hdl/csa_div.sv =====
// csa_div: unsigned 32-bit restoring divider, four quotient bits per stage
// depends on csa_pkg
module csa_div (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_n,
    input  logic [31:0] i_d,
    output logic [31:0] o_q
);
    import csa_pkg::*;

    logic [31:0] r_rem [DivSteps];
    logic [31:0] r_num [DivSteps];
    logic [31:0] r_den [DivSteps];

    for (genvar s = 0; s < DivSteps; s++) begin : g_stage
        logic [31:0] rem_in, num_in, den_in;
        logic [31:0] rem_o, num_o;
        logic [32:0] trial;
        if (s == 0) begin : g_first
            assign rem_in = '0;
            assign num_in = i_n;
            assign den_in = i_d;
        end else begin : g_next
            assign rem_in = r_rem[s-1];
            assign num_in = r_num[s-1];
            assign den_in = r_den[s-1];
        end
        always_comb begin
            rem_o = rem_in;
            num_o = num_in;
            for (int k = 0; k < DivBits; k++) begin
                trial = {rem_o, num_o[31]} - {1'b0, den_in};
                num_o = {num_o[30:0], 1'b0};
                if (!trial[32]) begin
                    rem_o = trial[31:0];
                    num_o[0] = 1'b1;
                end else begin
                    rem_o = {rem_o[30:0], num_in[31-(k % 32)]};
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= rem_o;
                r_num[s] <= num_o;
                r_den[s] <= den_in;
            end
        end
    end

    assign o_q = r_num[DivSteps-1];
endmodule

// ===== hdl/checked_signed_alu_top.sv =====
// checked_signed_alu_top: pipelined checked signed alu
// depends on csa_pkg, csa_mul, csa_div
//
// channel | direction | signals
// in      | input     | i_valid, o_ready, i_command, i_operand_a, i_operand_b
// out     | output    | o_valid, i_ready, o_value, o_status
//
// one item per cycle while the output is not stalled; an accepted item passes through these registers in order:
// operand prep at the accepting edge, eight divider stages, then the result register
// reset clears all valid bits; payload registers are not reset
// the whole pipeline holds while the output item waits; o_ready is high while o_valid is low or i_ready is high
module checked_signed_alu_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [1:0]          i_command,
    input  logic signed [31:0]  i_operand_a,
    input  logic signed [31:0]  i_operand_b,
    output logic                o_valid,
    input  logic                i_ready,
    output logic signed [31:0]  o_value,
    output logic [1:0]          o_status
);
    import csa_pkg::*;

    localparam int unsigned Lat = DivSteps + 1;

    logic en;
    assign en = !o_valid || i_ready;
    assign o_ready = en;

    // stage 0: operand prep
    t_ctl        r_ctl [Lat];
    logic [32:0] r_as [Lat];
    logic [31:0] r_mag_a, r_mag_b;
    logic [31:0] r_a0, r_b0;

    t_ctl        n_ctl0;
    logic [31:0] mag_a, mag_b;
    always_comb begin
        mag_a = i_operand_a[31] ? 32'(-i_operand_a) : i_operand_a;
        mag_b = i_operand_b[31] ? 32'(-i_operand_b) : i_operand_b;
        n_ctl0.vld     = i_valid;
        n_ctl0.cmd     = t_cmd'(i_command);
        n_ctl0.neg_q   = i_operand_a[31] ^ i_operand_b[31];
        n_ctl0.zero_b  = (i_operand_b == '0);
        n_ctl0.ovf_div = (i_operand_a == 32'h8000_0000) && (i_operand_b == '1);
    end

    logic [32:0] n_as0;
    always_comb begin
        if (t_cmd'(i_command) == CMD_SUB) begin
            n_as0 = 33'(signed'(i_operand_a)) - 33'(signed'(i_operand_b));
        end else begin
            n_as0 = 33'(signed'(i_operand_a)) + 33'(signed'(i_operand_b));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < Lat; s++) r_ctl[s].vld <= 1'b0;
        end else if (en) begin
            r_ctl[0].vld <= n_ctl0.vld;
            for (int s = 1; s < Lat; s++) r_ctl[s].vld <= r_ctl[s-1].vld;
        end
        if (en) begin
            r_ctl[0].cmd     <= n_ctl0.cmd;
            r_ctl[0].neg_q   <= n_ctl0.neg_q;
            r_ctl[0].zero_b  <= n_ctl0.zero_b;
            r_ctl[0].ovf_div <= n_ctl0.ovf_div;
            for (int s = 1; s < Lat; s++) begin
                r_ctl[s].cmd     <= r_ctl[s-1].cmd;
                r_ctl[s].neg_q   <= r_ctl[s-1].neg_q;
                r_ctl[s].zero_b  <= r_ctl[s-1].zero_b;
                r_ctl[s].ovf_div <= r_ctl[s-1].ovf_div;
            end
            r_as[0] <= n_as0;
            for (int s = 1; s < Lat; s++) r_as[s] <= r_as[s-1];
            r_mag_a <= mag_a;
            r_mag_b <= mag_b;
            r_a0    <= i_operand_a;
            r_b0    <= i_operand_b;
        end
    end

    // multiplier: stages 1..2, delayed to line up with divider
    logic [63:0] prod;
    logic [63:0] r_prod [Lat-3];
    csa_mul u_mul (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (r_a0),
        .i_b   (r_b0),
        .o_p   (prod)
    );
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prod[0] <= prod;
            for (int s = 1; s < Lat-3; s++) r_prod[s] <= r_prod[s-1];
        end
    end

    // divider: stages 1..8
    logic [31:0] quo;
    csa_div u_div (
        .i_clk (i_clk),
        .i_en  (en),
        .i_n   (r_mag_a),
        .i_d   (r_mag_b),
        .o_q   (quo)
    );

    // final check stage
    t_ctl        c;
    logic [32:0] as_v;
    logic [63:0] p_v;
    logic [31:0] q_s;
    logic [31:0] n_value;
    t_status     n_status;
    assign c    = r_ctl[Lat-1];
    assign as_v = r_as[Lat-1];
    assign p_v  = r_prod[Lat-4];
    always_comb begin
        q_s = c.neg_q ? 32'(-quo) : quo;
        n_value  = '0;
        n_status = ST_OK;
        unique case (c.cmd)
            CMD_ADD, CMD_SUB: begin
                if (as_v[32] != as_v[31]) n_status = ST_RANGE;
                else n_value = as_v[31:0];
            end
            CMD_MUL: begin
                if (p_v[63:31] != {33{p_v[31]}}) n_status = ST_RANGE;
                else n_value = p_v[31:0];
            end
            CMD_DIV: begin
                if (c.zero_b) n_status = ST_DIVZERO;
                else if (c.ovf_div) n_status = ST_RANGE;
                else n_value = q_s;
            end
            default: n_status = ST_OK;
        endcase
    end

    logic        r_ovld;
    logic [31:0] r_value;
    t_status     r_status;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (en) begin
            r_ovld <= c.vld;
        end
        if (en) begin
            r_value  <= n_value;
            r_status <= n_status;
        end
    end

    assign o_valid  = r_ovld;
    assign o_value  = r_value;
    assign o_status = r_status;
endmodule
